/* rtl/core/kcf_pkg.sv */
// ----------------------------------------------------------------------------
// kcf_pkg
// Shared types and constants of the keyframe color fader.
// ----------------------------------------------------------------------------
package kcf_pkg;

  localparam int unsigned TOT_W   = 40;

  localparam logic [7:0]  PERCENT_FULL = 8'd100;
  localparam logic [7:0]  COLOR_MAX    = 8'd255;
  localparam logic [31:0] RATE_START   = 32'h6464_6464;

  // Division by 100 of a product: (v * 5243) >> 19 is exact for v below 43699.
  localparam logic [12:0] SCALE_RECIP = 13'd5243;
  localparam int unsigned SCALE_SHIFT = 19;

  typedef enum logic [2:0] {
    REG_BASE_ALPHA = 3'd0,
    REG_BASE_RED   = 3'd1,
    REG_BASE_GREEN = 3'd2,
    REG_BASE_BLUE  = 3'd3,
    REG_ENABLE     = 3'd4,
    REG_SEG_COUNT  = 3'd5
  } reg_index_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  typedef struct packed {
    logic        op;
    logic [3:0]  seg_index;
    logic [31:0] seg_duration;
    logic [7:0]  seg_alpha_rate;
    logic [7:0]  seg_red_rate;
    logic [7:0]  seg_green_rate;
    logic [7:0]  seg_blue_rate;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_alpha;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [3:0] active_segment;
    logic       bypassed;
  } out_item_t;

  // Handshake between the sequencer and the shared divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  typedef struct packed {
    logic done;
  } div_rsp_t;

endpackage

/* rtl/core/kcf_if.sv */
// ----------------------------------------------------------------------------
// kcf_in_if / kcf_out_if
// Valid/ready channels carrying input and result items.
// ----------------------------------------------------------------------------
interface kcf_in_if;
  logic             valid;
  logic             ready;
  kcf_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface kcf_out_if;
  logic              valid;
  logic              ready;
  kcf_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/kcf_ram.sv */
// ----------------------------------------------------------------------------
// kcf_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module kcf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/kcf_div.sv */
// ----------------------------------------------------------------------------
// kcf_div
// Restoring divider, one quotient bit per cycle. Gives quotient and remainder.
// ----------------------------------------------------------------------------
module kcf_div #(
  parameter int unsigned W = 40
) (
  input  logic              clk,
  input  logic              rst,
  input  kcf_pkg::div_req_t req,
  input  logic [W-1:0]      dividend,
  input  logic [W-1:0]      divisor,
  output kcf_pkg::div_rsp_t rsp,
  output logic [W-1:0]      quotient,
  output logic [W-1:0]      remainder
);

  localparam int unsigned CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [W:0]    trial;
  logic [W:0]    diff;

  always_comb begin
    trial = {rem, quo[W-1]};
    diff  = trial - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
    end else begin
      rsp.done <= !req.start && busy && (cnt == CW'(1));
      if (req.start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        dsr  <= divisor;
        cnt  <= CW'(W);
      end else if (busy) begin
        if (!diff[W]) begin
          rem <= diff[W-1:0];
          quo <= {quo[W-2:0], 1'b1};
        end else begin
          rem <= trial[W-1:0];
          quo <= {quo[W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

/* rtl/core/keyframe_color_fader.sv */
// ----------------------------------------------------------------------------
// keyframe_color_fader
// Piecewise linear keyframe color envelope over a segment table in RAM.
// ----------------------------------------------------------------------------
// One item at a time, and a new item is taken only once the previous result
// has been accepted. After reset a clearing pass zeroes all MAX_SEGMENTS
// entries of both tables, during which no item is taken. A write item stores
// its segment in both RAMs if its index is within the table. An evaluate item
// sums the active durations from the duration RAM, takes the time modulo the
// total on a 40-bit serial divider, walks the table again up to the hit, runs
// four interpolation divisions on the same divider and scales the four colors
// by a reciprocal multiplication. A bypassed evaluation skips the divider and
// returns the base colors.
module keyframe_color_fader #(
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  kcf_in_if.sink      in_ch,
  kcf_out_if.source   out_ch
);

  localparam int unsigned AW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned TW = kcf_pkg::TOT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_WRITE, S_SUM, S_MOD, S_FIND, S_FETCH, S_LERP, S_SCALE, S_OUT
  } state_t;

  state_t state;

  logic [7:0] base [4];
  logic       enable;
  logic [4:0] seg_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      base[0]   <= kcf_pkg::COLOR_MAX;
      base[1]   <= kcf_pkg::COLOR_MAX;
      base[2]   <= kcf_pkg::COLOR_MAX;
      base[3]   <= kcf_pkg::COLOR_MAX;
      enable    <= 1'b0;
      seg_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        kcf_pkg::REG_BASE_ALPHA: base[0] <= cfg_data;
        kcf_pkg::REG_BASE_RED:   base[1] <= cfg_data;
        kcf_pkg::REG_BASE_GREEN: base[2] <= cfg_data;
        kcf_pkg::REG_BASE_BLUE:  base[3] <= cfg_data;
        kcf_pkg::REG_ENABLE:     enable  <= cfg_data[0];
        kcf_pkg::REG_SEG_COUNT:  seg_count <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Effective count, clamped to the table size.
  logic [CW-1:0] count;
  always_comb begin
    if (32'(seg_count) > 32'(MAX_SEGMENTS)) count = CW'(MAX_SEGMENTS);
    else count = CW'(seg_count);
  end

  // Segment RAMs: durations and packed rates.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [AW-1:0]     ram_raddr;
  logic [31:0]       dur_rd;
  logic [31:0]       rate_rd;
  logic [31:0]       dur_wd;
  logic [31:0]       rate_wd;
  logic [31:0]       clr_dur;
  logic [31:0]       clr_rate;

  kcf_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_dur_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(dur_wd),
    .raddr(ram_raddr), .rdata(dur_rd)
  );
  kcf_ram #(.WIDTH(32), .DEPTH(MAX_SEGMENTS)) u_rate_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(rate_wd),
    .raddr(ram_raddr), .rdata(rate_rd)
  );

  // Reset clearing pass over the table.
  logic          clearing;
  logic [CW-1:0] clr_ptr;

  // Divider.
  kcf_pkg::div_req_t dreq;
  kcf_pkg::div_rsp_t drsp;
  logic [TW-1:0]     dvd;
  logic [TW-1:0]     dvs;
  logic [TW-1:0]     dq;
  logic [TW-1:0]     dr;
  logic              div_go;

  kcf_div #(.W(TW)) u_div (
    .clk(clk), .rst(rst), .req(dreq), .dividend(dvd), .divisor(dvs),
    .rsp(drsp), .quotient(dq), .remainder(dr)
  );

  kcf_pkg::in_item_t  item;
  kcf_pkg::out_item_t result;
  logic               out_valid;

  logic [CW-1:0] ptr;
  logic          rd_pend;
  logic [TW-1:0] total;
  logic [TW-1:0] tmod;
  logic [TW-1:0] acc;
  logic [31:0]   elapsed;
  logic [AW-1:0] found;
  logic [31:0]   from_r;
  logic [31:0]   to_r;
  logic [31:0]   seg_dur;
  logic [1:0]    lane;
  logic          div_wait;
  logic [7:0]    from_b;
  logic [7:0]    to_b;
  logic          lerp_up;
  logic [7:0]    lerp_diff;
  logic [TW-1:0] lerp_prod;
  logic [7:0]    rate_l [4];
  logic [TW-1:0] acc_next;
  logic [15:0]   scale_prod;
  logic [28:0]   scale_full;
  logic [9:0]    scale_q;
  logic [7:0]    scale_sat;

  assign acc_next = acc + TW'(dur_rd);

  always_comb begin
    from_b    = from_r[8*lane +: 8];
    to_b      = to_r[8*lane +: 8];
    lerp_up   = to_b > from_b;
    lerp_diff = lerp_up ? (to_b - from_b) : (from_b - to_b);
    lerp_prod = {32'd0, lerp_diff} * {8'd0, elapsed};
  end

  always_comb begin
    scale_full = {13'd0, scale_prod} * {16'd0, kcf_pkg::SCALE_RECIP};
    scale_q    = scale_full[kcf_pkg::SCALE_SHIFT +: 10];
    scale_sat  = (scale_q > 10'd255) ? kcf_pkg::COLOR_MAX : scale_q[7:0];
  end

  // The divider is started from the sum walk and from each interpolation lane.
  always_comb begin
    div_go = ((state == S_SUM) && !(ptr < count) && !rd_pend && enable
              && (total != '0))
             || ((state == S_LERP) && !div_wait);
  end

  always_comb begin
    ram_we    = clearing || (state == S_WRITE
                && 32'(item.seg_index) < 32'(MAX_SEGMENTS));
    ram_waddr = clearing ? clr_ptr[AW-1:0] : item.seg_index[AW-1:0];
    clr_dur   = clearing ? '0 : item.seg_duration;
    clr_rate  = clearing ? '0 : {item.seg_blue_rate, item.seg_green_rate,
                                 item.seg_red_rate, item.seg_alpha_rate};
    ram_raddr = ptr[AW-1:0];
    dur_wd    = clr_dur;
    rate_wd   = clr_rate;
  end

  assign in_ch.ready  = (state == S_IDLE) && !clearing && !out_valid;
  assign out_ch.valid = out_valid;
  assign out_ch.data  = result;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      clearing  <= 1'b1;
      clr_ptr   <= '0;
      dreq      <= '0;
      div_wait  <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      dreq.start <= div_go;
      if (out_valid && out_ch.ready) out_valid <= 1'b0;
      if (clearing) begin
        clr_ptr <= clr_ptr + 1'b1;
        if (clr_ptr == CW'(MAX_SEGMENTS - 1)) clearing <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_ch.valid && !clearing && !out_valid) begin
            item <= in_ch.data;
            if (in_ch.data.op == kcf_pkg::OP_WRITE) begin
              state <= S_WRITE;
            end else begin
              state   <= S_SUM;
              ptr     <= '0;
              total   <= '0;
              rd_pend <= 1'b0;
            end
          end
        end
        S_WRITE: state <= S_IDLE;
        S_SUM: begin
          // The read issued last cycle returns now.
          if (rd_pend) total <= total + TW'(dur_rd);
          if (ptr < count) begin
            ptr     <= ptr + 1'b1;
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              if (!enable || total == '0) begin
                result.out_alpha      <= base[0];
                result.out_red        <= base[1];
                result.out_green      <= base[2];
                result.out_blue       <= base[3];
                result.active_segment <= '0;
                result.bypassed       <= 1'b1;
                state                 <= S_OUT;
              end else begin
                dvd   <= TW'(item.now_ms);
                dvs   <= total;
                state <= S_MOD;
              end
            end
          end
        end
        S_MOD: begin
          if (drsp.done) begin
            tmod    <= dr;
            acc     <= '0;
            ptr     <= '0;
            rd_pend <= 1'b0;
            from_r  <= kcf_pkg::RATE_START;
            state   <= S_FIND;
          end
        end
        S_FIND: begin
          // Walk until the running sum passes the time; a hit always exists.
          if (rd_pend) begin
            rd_pend <= 1'b0;
            if (tmod < acc_next) begin
              found   <= AW'(ptr - 1'b1);
              elapsed <= 32'(tmod - acc);
              to_r    <= rate_rd;
              seg_dur <= dur_rd;
              lane    <= '0;
              state   <= S_LERP;
              div_wait <= 1'b0;
            end else begin
              acc    <= acc_next;
              from_r <= rate_rd;
            end
          end else begin
            ptr     <= ptr + 1'b1;
            rd_pend <= 1'b1;
          end
        end
        S_LERP: begin
          if (!div_wait) begin
            dvd      <= lerp_prod;
            dvs      <= TW'(seg_dur);
            div_wait <= 1'b1;
          end else if (drsp.done) begin
            rate_l[lane] <= lerp_up ? from_b + dq[7:0] : from_b - dq[7:0];
            div_wait     <= 1'b0;
            lane         <= lane + 1'b1;
            if (lane == 2'd3) state <= S_SCALE;
          end
        end
        S_SCALE: begin
          // The product is formed and registered first, then divided by 100.
          if (!div_wait) begin
            scale_prod <= {8'd0, base[lane]} * {8'd0, rate_l[lane]};
            div_wait   <= 1'b1;
          end else begin
            div_wait <= 1'b0;
            lane     <= lane + 1'b1;
            unique case (lane)
              2'd0: result.out_alpha <= scale_sat;
              2'd1: result.out_red   <= scale_sat;
              2'd2: result.out_green <= scale_sat;
              2'd3: result.out_blue  <= scale_sat;
            endcase
            if (lane == 2'd3) begin
              result.active_segment <= 4'(found);
              result.bypassed       <= 1'b0;
              state                 <= S_OUT;
            end
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/keyframe_color_fader_tb.sv */
// ----------------------------------------------------------------------------
// keyframe_color_fader_tb
// Checks the keyframe color fader against an in-bench envelope predictor
// while both channels idle in random bursts and the settings are changed.
// ----------------------------------------------------------------------------
module keyframe_color_fader_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SEGS = 16;
  localparam int DRAIN_CYCLES = 700;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = kcf_pkg::REG_BASE_ALPHA;
  logic [7:0] cfg_data = '0;

  kcf_in_if in_ch ();
  kcf_out_if out_ch ();

  keyframe_color_fader #(.MAX_SEGMENTS(SEGS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state.
  logic [31:0] seg_dur [SEGS];
  logic [31:0] seg_rates [SEGS];
  logic [7:0] base_color [4];
  logic fade_on;
  logic [4:0] seg_count;

  kcf_pkg::in_item_t pending_items[$];
  kcf_pkg::out_item_t expected_colors[$];
  int errors = 0;
  int evals_seen = 0;
  int writes_sent = 0;
  int bypass_seen = 0;
  bit calm = 1'b0;
  bit in_done = 1'b0;
  int src_gap = 0;
  int snk_gap = 0;

  function automatic logic [7:0] lerp_pct(logic [7:0] from, logic [7:0] to,
                                         logic [63:0] el, logic [63:0] dur);
    logic [63:0] step;
    if (to > from) begin
      step = ((to - from) * el) / dur;
      return from + step[7:0];
    end
    step = ((from - to) * el) / dur;
    return from - step[7:0];
  endfunction

  function automatic logic [7:0] scaled(logic [7:0] base, logic [7:0] rate);
    logic [31:0] v;
    v = (32'(base) * 32'(rate)) / 32'(kcf_pkg::PERCENT_FULL);
    return (v > 32'd255) ? 8'd255 : v[7:0];
  endfunction

  function automatic void predict_color(kcf_pkg::in_item_t it);
    kcf_pkg::out_item_t r;
    int cnt;
    int hit;
    logic [63:0] total, t, acc, start;
    logic [31:0] from, to;
    logic [7:0] col [4];
    if (it.op == kcf_pkg::OP_WRITE) begin
      seg_dur[it.seg_index] = it.seg_duration;
      seg_rates[it.seg_index] = {it.seg_blue_rate, it.seg_green_rate,
                                 it.seg_red_rate, it.seg_alpha_rate};
      return;
    end
    cnt = (seg_count > SEGS) ? SEGS : seg_count;
    total = 0;
    for (int i = 0; i < cnt; i++) total += seg_dur[i];
    if (!fade_on || total == 0) begin
      r = '{base_color[0], base_color[1], base_color[2], base_color[3], 4'd0, 1'b1};
      expected_colors.push_back(r);
      return;
    end
    t = 64'(it.now_ms) % total;
    acc = 0;
    start = 0;
    hit = 0;
    for (int i = 0; i < cnt; i++) begin
      start = acc;
      acc += seg_dur[i];
      if (t < acc) begin
        hit = i;
        break;
      end
    end
    from = (hit > 0) ? seg_rates[hit-1] : kcf_pkg::RATE_START;
    to = seg_rates[hit];
    for (int c = 0; c < 4; c++)
      col[c] = scaled(base_color[c],
        lerp_pct(from[8*c +: 8], to[8*c +: 8], t - start, 64'(seg_dur[hit])));
    r.out_alpha = col[0];
    r.out_red = col[1];
    r.out_green = col[2];
    r.out_blue = col[3];
    r.active_segment = hit[3:0];
    r.bypassed = 1'b0;
    expected_colors.push_back(r);
  endfunction

  // Driver: the predictor runs when an item is accepted.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready) begin
      predict_color(in_ch.data);
      void'(pending_items.pop_front());
      in_done = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.data <= '0;
      out_ch.ready <= 1'b0;
      in_done = 1'b0;
    end else begin
      // An item that is still waiting keeps its valid and data.
      if (!in_ch.valid || in_done) begin
        in_done = 1'b0;
        if (src_gap > 0) src_gap--;
        else if (!calm && $urandom_range(0, 9) == 0) src_gap = $urandom_range(1, 6);
        if (src_gap == 0 && pending_items.size() > 0) begin
          in_ch.valid <= 1'b1;
          in_ch.data <= pending_items[0];
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (snk_gap > 0) snk_gap--;
      else if (!calm && $urandom_range(0, 7) == 0) snk_gap = $urandom_range(1, 6);
      out_ch.ready <= (snk_gap == 0);
    end
  end

  // Monitor.
  always @(posedge clk) begin
    kcf_pkg::out_item_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      evals_seen++;
      if (out_ch.data.bypassed) bypass_seen++;
      if (expected_colors.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_ch.data);
        errors++;
      end else begin
        want = expected_colors.pop_front();
        if (want !== out_ch.data) begin
          $display("%0t: expected a=%0d r=%0d g=%0d b=%0d seg=%0d byp=%0b", $time,
                   want.out_alpha, want.out_red, want.out_green, want.out_blue,
                   want.active_segment, want.bypassed);
          $display("%0t: actual   a=%0d r=%0d g=%0d b=%0d seg=%0d byp=%0b", $time,
                   out_ch.data.out_alpha, out_ch.data.out_red, out_ch.data.out_green,
                   out_ch.data.out_blue, out_ch.data.active_segment,
                   out_ch.data.bypassed);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(kcf_pkg::reg_index_t idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      kcf_pkg::REG_BASE_ALPHA: base_color[0] = val;
      kcf_pkg::REG_BASE_RED:   base_color[1] = val;
      kcf_pkg::REG_BASE_GREEN: base_color[2] = val;
      kcf_pkg::REG_BASE_BLUE:  base_color[3] = val;
      kcf_pkg::REG_ENABLE:     fade_on = val[0];
      kcf_pkg::REG_SEG_COUNT:  seg_count = val[4:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || expected_colors.size() > 0) @(posedge clk);
    // A trailing write item may still be in flight.
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_dur();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 32'hFFFF_FFFF - $urandom_range(0, 3);
      2: return $urandom();
      default: return $urandom_range(1, 400);
    endcase
  endfunction

  function automatic logic [7:0] pick_rate();
    case ($urandom_range(0, 5))
      0: return 8'd255;
      1: return 8'd0;
      2: return 8'($urandom_range(0, 255));
      default: return 8'($urandom_range(0, 200));
    endcase
  endfunction

  task automatic queue_write(int idx, logic [31:0] dur, logic [7:0] a, logic [7:0] r,
                             logic [7:0] g, logic [7:0] b);
    kcf_pkg::in_item_t it;
    it = '{kcf_pkg::OP_WRITE, idx[3:0], dur, a, r, g, b, $urandom()};
    pending_items.push_back(it);
    writes_sent++;
  endtask

  task automatic queue_eval(logic [31:0] now);
    kcf_pkg::in_item_t it;
    it = '{kcf_pkg::OP_EVAL, 4'($urandom()), $urandom(), 8'($urandom()),
           8'($urandom()), 8'($urandom()), 8'($urandom()), now};
    pending_items.push_back(it);
  endtask

  task automatic random_phase(int n);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 4) == 0)
        queue_write($urandom_range(0, 15), pick_dur(), pick_rate(), pick_rate(),
                    pick_rate(), pick_rate());
      else
        queue_eval(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 3000));
    end
    wait_idle();
  endtask

  initial begin
    for (int i = 0; i < SEGS; i++) begin
      seg_dur[i] = '0;
      seg_rates[i] = '0;
    end
    for (int c = 0; c < 4; c++) base_color[c] = 8'd255;
    fade_on = 1'b0;
    seg_count = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: bypass after reset, then extremes.
    queue_eval(32'hFFFF_FFFF);
    queue_eval(32'd0);
    wait_idle();
    write_reg(kcf_pkg::REG_ENABLE, 8'd1);
    write_reg(kcf_pkg::REG_SEG_COUNT, 8'd4);
    queue_eval(32'd5);
    queue_write(0, 32'd100, 8'd0, 8'd255, 8'd100, 8'd50);
    queue_write(1, 32'd0, 8'd255, 8'd0, 8'd200, 8'd7);
    queue_write(2, 32'hFFFF_FFFF, 8'd10, 8'd250, 8'd100, 8'd255);
    queue_write(3, 32'hFFFF_FFFF, 8'd255, 8'd255, 8'd255, 8'd255);
    queue_write(15, 32'd1, 8'hAA, 8'h55, 8'hAA, 8'h55);
    for (int k = 0; k < 6; k++) queue_eval($urandom());
    queue_eval(32'd0);
    queue_eval(32'd99);
    queue_eval(32'd100);
    queue_eval(32'hFFFF_FFFF);
    wait_idle();
    write_reg(kcf_pkg::REG_SEG_COUNT, 8'd31);
    write_reg(kcf_pkg::REG_BASE_ALPHA, 8'd0);
    write_reg(kcf_pkg::REG_BASE_RED, 8'd255);
    write_reg(kcf_pkg::REG_BASE_GREEN, 8'd1);
    write_reg(kcf_pkg::REG_BASE_BLUE, 8'd128);
    queue_eval(32'hFFFF_FFFF);
    queue_eval(32'd12345);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      write_reg(kcf_pkg::REG_BASE_ALPHA, 8'($urandom()));
      write_reg(kcf_pkg::REG_BASE_RED, 8'($urandom()));
      write_reg(kcf_pkg::REG_BASE_GREEN, 8'($urandom()));
      write_reg(kcf_pkg::REG_BASE_BLUE, 8'($urandom()));
      write_reg(kcf_pkg::REG_ENABLE, (p % 5 == 4) ? 8'd0 : 8'd1);
      write_reg(kcf_pkg::REG_SEG_COUNT, (p == 3) ? 8'd0 : 8'($urandom_range(0, 31)));
      if (p == 9) calm = 1'b1;
      random_phase(165);
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Run covered %0d segment writes and %0d evaluations (%0d bypassed).",
             writes_sent, evals_seen, bypass_seen);
    if (errors == 0 && expected_colors.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(30_000_000ns);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* files.f */
rtl/core/kcf_pkg.sv
rtl/core/kcf_if.sv
rtl/core/kcf_ram.sv
rtl/core/kcf_div.sv
rtl/core/keyframe_color_fader.sv
verif/keyframe_color_fader_tb.sv
